@@ design/wsg_pkg.sv @@
// Package: shared types, constants and state codes for the wavetable sound generator.
package wsg_pkg;

  localparam int RamDepth   = 128;
  localparam int RamAw      = 7;
  localparam int RamDw      = 8;
  localparam int ChanBase   = 64;
  localparam logic [RamAw-1:0] CountReg = 7'h7F;
  localparam logic [3:0] TicksPerUpdate = 4'd15;

  typedef enum logic [1:0] {
    CMD_SET_ADDR = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_READ     = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WRITE_RD,
    ST_WRITE_WB,
    ST_READ_RD,
    ST_READ_WAIT,
    ST_TICK,
    ST_U_RD,
    ST_U_CAP,
    ST_U_MOD,
    ST_U_WRP0,
    ST_U_WRP1,
    ST_U_WRP2,
    ST_U_SRD,
    ST_U_SCAP,
    ST_U_MIX,
    ST_U_DIV,
    ST_DONE
  } state_t;

endpackage

@@ design/wsg_if.sv @@
// Valid/ready channel interfaces for commands and results.
interface wsg_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] value;
  logic [7:0] tick_count;
  modport source (output valid, cmd, value, tick_count, input ready);
  modport sink (input valid, cmd, value, tick_count, output ready);
endinterface

interface wsg_out_if (input logic clk);
  logic              valid;
  logic              ready;
  logic [7:0]        read_data;
  logic              changed;
  logic signed [7:0] mix_out;
  modport source (output valid, read_data, changed, mix_out, input ready);
  modport sink (input valid, read_data, changed, mix_out, output ready);
endinterface

@@ design/wsg_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module wsg_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ design/wsg_divmod.sv @@
// Iterative restoring divider: one quotient bit per cycle.
module wsg_divmod #(
  parameter int Width = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [Width-1:0] dividend,
  input  logic [Width-1:0] divisor,
  output logic             busy,
  output logic [Width-1:0] quot,
  output logic [Width-1:0] rem
);
  localparam int Cw = $clog2(Width + 1);
  logic [Width-1:0] q_r, q_nxt, r_r, r_nxt, d_r;
  logic [Cw-1:0]    cnt_r, cnt_nxt;
  logic [Width:0]   trial;

  always_comb begin
    q_nxt   = q_r;
    r_nxt   = r_r;
    cnt_nxt = cnt_r;
    trial   = {r_r, q_r[Width-1]};
    if (start) begin
      q_nxt   = dividend;
      r_nxt   = '0;
      cnt_nxt = Cw'(Width);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = Width'(trial - {1'b0, d_r});
        q_nxt = {q_r[Width-2:0], 1'b1};
      end else begin
        r_nxt = trial[Width-1:0];
        q_nxt = {q_r[Width-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = q_r;
  assign rem  = r_r;
endmodule

@@ design/wavetable_sound_generator_core.sv @@
// Top level of the wavetable sound generator core.
// After reset a clearing pass zeroes the 128-byte RAM, and no command is
// taken until it ends. Every command ends in a done state that posts the
// result; a read or write first reads the RAM, and a tick command counts its
// ticks down. Every 15 enabled ticks a channel update reads the eight channel
// bytes and the count register, takes the phase modulo, fetches a sample,
// writes the phase back in three bytes, sums the active channel levels and
// divides the sum by the channel count. A stalled result holds the core until
// it is taken. The single RAM port and the iterative divider make these steps
// run one after another.
module wavetable_sound_generator_core
  import wsg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  wsg_in_if.sink     in_ch,
  wsg_out_if.source  out_ch
);
  state_t state_r, state_nxt;

  logic             dis_r;
  logic [RamAw-1:0] ptr_r, ptr_nxt;
  logic             inc_r, inc_nxt;
  logic [3:0]       divc_r, divc_nxt;
  logic [2:0]       act_r, act_nxt;
  logic [7:0]       lvl_r [8];
  logic [7:0]       mix_r, mix_nxt;
  logic [7:0]       ticks_r, ticks_nxt;
  logic [7:0]       val_r, val_nxt;
  logic             chg_r, chg_nxt;
  logic [7:0]       rd_r, rd_nxt;
  logic [RamAw-1:0] clr_r, clr_nxt;
  logic [3:0]       bi_r, bi_nxt;
  logic [7:0]       cb_r [8];
  logic [23:0]      ph_r, ph_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [2:0]       mi_r, mi_nxt;
  logic signed [10:0] sum_r, sum_nxt;
  logic [7:0]       lvl_new_r, lvl_new_nxt;
  logic             lvl_we;
  logic [2:0]       cnt_m1_r, cnt_m1_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       ord_r, ord_nxt;
  logic             ochg_r, ochg_nxt;
  logic [7:0]       omix_r, omix_nxt;

  logic             ram_we;
  logic [RamAw-1:0] ram_addr;
  logic [7:0]       ram_wd, ram_rd;

  logic             dv_start, dv_busy;
  logic [24:0]      dv_a, dv_b, dv_q, dv_r;

  logic [24:0] sum_ph;
  logic [8:0]  wlen;
  logic [2:0]  lowest;
  logic [3:0]  smp;
  logic signed [4:0] cent;
  logic signed [9:0] prod;
  logic [3:0]  cnt_w;

  wsg_ram #(.Width(RamDw), .Depth(RamDepth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  wsg_divmod #(.Width(25)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .busy(dv_busy), .quot(dv_q), .rem(dv_r)
  );

  assign sum_ph  = {1'b0, cb_r[5], cb_r[3], cb_r[1]}
                 + {7'd0, cb_r[4][1:0], cb_r[2], cb_r[0]};
  assign wlen    = 9'd256 - {1'b0, cb_r[4][7:2], 2'b00};
  assign lowest  = 3'd7 - cnt_m1_r;
  assign smp     = pos_r[0] ? ram_rd[7:4] : ram_rd[3:0];
  assign cent    = $signed({1'b0, smp}) - 5'sd8;
  assign prod    = cent * $signed({1'b0, cb_r[7][3:0]});
  assign cnt_w   = {1'b0, cnt_m1_r} + 4'd1;

  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    inc_nxt     = inc_r;
    divc_nxt    = divc_r;
    act_nxt     = act_r;
    mix_nxt     = mix_r;
    ticks_nxt   = ticks_r;
    val_nxt     = val_r;
    chg_nxt     = chg_r;
    rd_nxt      = rd_r;
    clr_nxt     = clr_r;
    bi_nxt      = bi_r;
    ph_nxt      = ph_r;
    pos_nxt     = pos_r;
    mi_nxt      = mi_r;
    sum_nxt     = sum_r;
    lvl_new_nxt = lvl_new_r;
    lvl_we      = 1'b0;
    cnt_m1_nxt  = cnt_m1_r;
    ovalid_nxt  = ovalid_r;
    ord_nxt     = ord_r;
    ochg_nxt    = ochg_r;
    omix_nxt    = omix_r;
    ram_we      = 1'b0;
    ram_addr    = ptr_r;
    ram_wd      = val_r;
    dv_start    = 1'b0;
    dv_a        = sum_ph;
    dv_b        = {wlen, 16'd0};
    in_ch.ready = 1'b0;

    if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        ram_wd   = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == CountReg) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          val_nxt   = in_ch.value;
          ticks_nxt = dis_r ? 8'd0 : in_ch.tick_count;
          chg_nxt   = 1'b0;
          rd_nxt    = '0;
          unique case (cmd_t'(in_ch.cmd))
            CMD_SET_ADDR: begin
              ptr_nxt   = in_ch.value[6:0];
              inc_nxt   = in_ch.value[7];
              state_nxt = ST_DONE;
            end
            CMD_WRITE: state_nxt = ST_WRITE_RD;
            CMD_READ:  state_nxt = ST_READ_RD;
            CMD_TICK:  state_nxt = ST_TICK;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_WRITE_RD: state_nxt = ST_WRITE_WB;
      ST_WRITE_WB: begin
        chg_nxt = (ram_rd != val_r);
        ram_we  = 1'b1;
        if (inc_r && ptr_r != CountReg) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_READ_RD: state_nxt = ST_READ_WAIT;
      ST_READ_WAIT: begin
        rd_nxt = ram_rd;
        if (inc_r && ptr_r != CountReg) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_TICK: begin
        if (ticks_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          ticks_nxt = ticks_r - 1'b1;
          if (divc_r + 1'b1 == TicksPerUpdate) begin
            divc_nxt  = '0;
            bi_nxt    = '0;
            state_nxt = ST_U_RD;
          end else begin
            divc_nxt = divc_r + 1'b1;
          end
        end
      end
      // read the eight channel bytes and the count register, each captured before the next is read
      ST_U_RD: begin
        ram_addr = (bi_r == 4'd8) ? CountReg : RamAw'(ChanBase + 8 * act_r + bi_r);
        state_nxt = ST_U_CAP;
      end
      ST_U_CAP: begin
        if (bi_r == 4'd8) begin
          cnt_m1_nxt = ram_rd[6:4];
          ph_nxt     = {cb_r[5], cb_r[3], cb_r[1]};
          state_nxt  = ST_U_MOD;
          dv_start   = 1'b1;
        end else begin
          bi_nxt    = bi_r + 1'b1;
          state_nxt = ST_U_RD;
        end
      end
      ST_U_MOD: begin
        if (!dv_busy && !dv_start) begin
          ph_nxt    = dv_r[23:0];
          pos_nxt   = dv_r[23:16] + cb_r[6];
          if (dv_r[23:0] != ph_r) begin
            chg_nxt = 1'b1;
          end
          state_nxt = ST_U_SRD;
        end
      end
      // sample is fetched before the new phase lands in the RAM
      ST_U_SRD: begin
        ram_addr  = pos_r[7:1];
        state_nxt = ST_U_SCAP;
      end
      ST_U_SCAP: begin
        lvl_new_nxt = prod[7:0];
        lvl_we      = 1'b1;
        sum_nxt     = '0;
        mi_nxt      = lowest;
        state_nxt   = ST_U_WRP0;
      end
      ST_U_WRP0: begin
        ram_we    = 1'b1;
        ram_addr  = RamAw'(ChanBase + 8 * act_r + 1);
        ram_wd    = ph_r[7:0];
        state_nxt = ST_U_WRP1;
      end
      ST_U_WRP1: begin
        ram_we    = 1'b1;
        ram_addr  = RamAw'(ChanBase + 8 * act_r + 3);
        ram_wd    = ph_r[15:8];
        state_nxt = ST_U_WRP2;
      end
      ST_U_WRP2: begin
        ram_we    = 1'b1;
        ram_addr  = RamAw'(ChanBase + 8 * act_r + 5);
        ram_wd    = ph_r[23:16];
        state_nxt = ST_U_MIX;
      end
      // accumulate active channel levels one per cycle
      ST_U_MIX: begin
        sum_nxt = sum_r + 11'($signed(lvl_r[mi_r]));
        if (mi_r == 3'd7) begin
          state_nxt = ST_U_DIV;
          dv_start  = 1'b1;
          dv_a      = {14'd0, (sum_nxt[10] ? 11'(-sum_nxt) : 11'(sum_nxt))};
          dv_b      = {21'd0, cnt_w};
        end else begin
          mi_nxt = mi_r + 1'b1;
        end
      end
      ST_U_DIV: begin
        if (!dv_busy && !dv_start) begin
          mix_nxt = sum_r[10] ? 8'(-dv_q[7:0]) : dv_q[7:0];
          if (act_r == 3'd0 || (act_r - 1'b1) < lowest) begin
            act_nxt = 3'd7;
          end else begin
            act_nxt = act_r - 1'b1;
          end
          state_nxt = ST_TICK;
        end
      end
      ST_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          ord_nxt    = rd_r;
          ochg_nxt   = chg_r;
          omix_nxt   = mix_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      dis_r    <= 1'b0;
      ptr_r    <= '0;
      inc_r    <= 1'b0;
      divc_r   <= '0;
      act_r    <= 3'd7;
      mix_r    <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        lvl_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      if (cfg_we) begin
        dis_r <= cfg_wdata;
      end
      ptr_r    <= ptr_nxt;
      inc_r    <= inc_nxt;
      divc_r   <= divc_nxt;
      act_r    <= act_nxt;
      mix_r    <= mix_nxt;
      ovalid_r <= ovalid_nxt;
      if (lvl_we) begin
        lvl_r[act_r] <= lvl_new_nxt;
      end
    end
    ticks_r   <= ticks_nxt;
    val_r     <= val_nxt;
    chg_r     <= chg_nxt;
    rd_r      <= rd_nxt;
    bi_r      <= bi_nxt;
    ph_r      <= ph_nxt;
    pos_r     <= pos_nxt;
    mi_r      <= mi_nxt;
    sum_r     <= sum_nxt;
    lvl_new_r <= lvl_new_nxt;
    cnt_m1_r  <= cnt_m1_nxt;
    ord_r     <= ord_nxt;
    ochg_r    <= ochg_nxt;
    omix_r    <= omix_nxt;
    if (state_r == ST_U_CAP && bi_r != 4'd8) begin
      cb_r[bi_r[2:0]] <= ram_rd;
    end
  end

  assign out_ch.valid     = ovalid_r;
  assign out_ch.read_data = ord_r;
  assign out_ch.changed   = ochg_r;
  assign out_ch.mix_out   = omix_r;
endmodule

@@ design/wsg_checker.sv @@
// Port-level assertions for the sound generator core, bound to the top level.
module wsg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_changed
);
  // a result stalled by the sink stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");
  // a command is never taken in the cycle after one was taken
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back accept");
  // a result never carries both read data and a change flag
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_changed |-> out_read_data == 8'd0)
    else $error("read data on a changing transaction");
  // nothing is taken at the start of the clearing pass after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("ready straight after reset");
endmodule

bind wavetable_sound_generator_core wsg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_read_data(out_ch.read_data), .out_changed(out_ch.changed)
);
